// ===== rtl/rcol_pkg.sv =====
`default_nettype none
package rcol_pkg;

  // result offset width: sum of two Q8.8 offsets
  localparam int unsigned TOTAL_W = 17;
  // width of the default offset registers
  localparam int unsigned CFG_W = 16;

  // run record acceptance and small-detector tower limits
  localparam logic [15:0] MIN_ENTRIES   = 16'd100;
  localparam logic [5:0]  SMALL_ROW_MAX = 6'd35;
  localparam logic [6:0]  SMALL_COL_MAX = 7'd71;

  // register select codes (paddr bit 2)
  localparam logic REG_DEFAULT_RUN   = 1'b0;
  localparam logic REG_DEFAULT_TOWER = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_SMALL = 2'd0,
    OP_LOAD_LARGE = 2'd1,
    OP_LOAD_TOWER = 2'd2,
    OP_QUERY      = 2'd3
  } rcol_op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_REJECTED    = 3'd1,
    ST_FULL        = 3'd2,
    ST_BAD_INDEX   = 3'd3,
    ST_SMALL_RANGE = 3'd4
  } rcol_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_FINISH
  } rcol_state_e;

  // run table walk result
  typedef struct packed {
    logic               done;
    logic [TOTAL_W-1:0] small_ofs;
    logic [TOTAL_W-1:0] large_ofs;
  } rcol_search_rsp_t;

  // sign-extend a default offset register to result width
  function automatic logic [TOTAL_W-1:0] sext_cfg(logic [CFG_W-1:0] v);
    return TOTAL_W'($signed(v));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rcol_run_table.sv =====
`default_nettype none
module rcol_run_table import rcol_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned OFS_W = 16,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned LANE_W = 24 + OFS_W
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             wlane_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [23:0]      wnum_i,
  input  wire logic [OFS_W-1:0] wofs_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic [23:0]           small_num_o,
  output logic [OFS_W-1:0]      small_ofs_o,
  output logic [23:0]           large_num_o,
  output logic [OFS_W-1:0]      large_ofs_o
);

  // lane 0 holds the small-detector table, lane 1 the large-detector table
  logic [1:0][LANE_W-1:0] mem_q [DEPTH];
  logic [1:0][LANE_W-1:0] rdata_q;

  // one lane written, both lanes read at one address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wlane_i] <= {wnum_i, wofs_i};
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign small_num_o = rdata_q[0][LANE_W-1:OFS_W];
  assign small_ofs_o = rdata_q[0][OFS_W-1:0];
  assign large_num_o = rdata_q[1][LANE_W-1:OFS_W];
  assign large_ofs_o = rdata_q[1][OFS_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/rcol_tower_table.sv =====
`default_nettype none
module rcol_tower_table #(
  parameter int unsigned DEPTH = 36864,
  parameter int unsigned WIDTH = 17,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/rcol_search.sv =====
`default_nettype none
module rcol_search import rcol_pkg::*; #(
  parameter int unsigned MAX_RUNS = 1024,
  parameter int unsigned OFS_W = 16,
  localparam int unsigned AW = $clog2(MAX_RUNS),
  localparam int unsigned CW = $clog2(MAX_RUNS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [23:0]      run_i,
  input  wire logic [CW-1:0]    n_small_i,
  input  wire logic [CW-1:0]    n_large_i,
  input  wire logic [CFG_W-1:0] default_run_i,
  input  wire logic [23:0]      small_num_i,
  input  wire logic [OFS_W-1:0] small_ofs_i,
  input  wire logic [23:0]      large_num_i,
  input  wire logic [OFS_W-1:0] large_ofs_i,
  output logic                  re_o,
  output logic [AW-1:0]         raddr_o,
  output rcol_search_rsp_t      rsp_o
);

  localparam int unsigned EXT_W = (OFS_W > TOTAL_W) ? OFS_W : TOTAL_W;

  function automatic logic [TOTAL_W-1:0] ext_ofs(logic [OFS_W-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'($signed(v));
    return w[TOTAL_W-1:0];
  endfunction

  logic                   busy_q;
  logic [AW-1:0]          idx_q;
  logic [1:0][23:0]       prev_num_q;
  logic [1:0][OFS_W-1:0]  prev_ofs_q;
  logic [1:0]             found_q;
  logic [1:0]             found_d;
  logic [1:0][TOTAL_W-1:0] res_q;
  logic [1:0][TOTAL_W-1:0] res_d;
  logic [1:0][TOTAL_W-1:0] fin_ofs;
  logic [1:0][23:0]       cur_num;
  logic [1:0][OFS_W-1:0]  cur_ofs;
  logic [1:0][CW-1:0]     cnt;
  logic [1:0]             hit_pair;
  logic [1:0]             at_end;
  rcol_search_rsp_t       rsp_q;
  logic [CW-1:0]          scan_n;
  logic [CW-1:0]          idx_ext;
  logic [CW-1:0]          idx_nxt;
  logic                   last;
  logic                   walk_done;

  assign cur_num = {large_num_i, small_num_i};
  assign cur_ofs = {large_ofs_i, small_ofs_i};
  assign cnt     = {n_large_i, n_small_i};

  // walk covers the longer of the two tables
  assign scan_n  = (n_small_i > n_large_i) ? n_small_i : n_large_i;
  assign idx_ext = CW'(idx_q);
  assign idx_nxt = idx_ext + CW'(1);
  assign last    = idx_nxt >= scan_n;

  // per table: first interval holding the run, else the last entry
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hit_pair[l] = busy_q && !found_q[l] && (idx_ext != '0) && (idx_ext < cnt[l]) &&
                    (prev_num_q[l] <= run_i) && (cur_num[l] > run_i);
      at_end[l]   = busy_q && !found_q[l] && (cnt[l] != '0) && (idx_ext == cnt[l] - CW'(1));
      found_d[l]  = found_q[l] | hit_pair[l];
      if (hit_pair[l]) begin
        res_d[l] = ext_ofs(prev_ofs_q[l]);
      end else if (at_end[l]) begin
        res_d[l] = ext_ofs(cur_ofs[l]);
      end else begin
        res_d[l] = res_q[l];
      end
      fin_ofs[l] = (cnt[l] == '0) ? sext_cfg(default_run_i) : res_d[l];
    end
  end

  // read address: entry 0 at start, then one entry per cycle
  assign re_o    = (start_i && (scan_n != '0)) || (busy_q && !last);
  assign raddr_o = start_i ? '0 : AW'(idx_nxt);

  // walk ends at once for empty tables, else after the last entry
  assign walk_done = start_i ? (scan_n == '0) : (busy_q && last);

  // walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rsp_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= (scan_n != '0);
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
      rsp_q.done <= walk_done;
      if (walk_done) begin
        rsp_q.small_ofs <= fin_ofs[0];
        rsp_q.large_ofs <= fin_ofs[1];
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      idx_q   <= '0;
      found_q <= '0;
    end else if (busy_q) begin
      idx_q      <= AW'(idx_nxt);
      found_q    <= found_d;
      res_q      <= res_d;
      prev_num_q <= cur_num;
      prev_ofs_q <= cur_ofs;
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/run_and_channel_offset_lookup_unit.sv =====
// flow: an accepted transaction passes through the EXEC state, then SEARCH for a query
//   missing the cached run, then FINISH, which loads the output register once it is free
// one transaction in flight at a time; a run-table walk reads one entry per cycle
// reset: counts, cache and handshake clear at once, then a sweep clears the tower
//   written bits of all 8*ROWS*COLUMNS entries (36864 by default) with in_stall_o high
`default_nettype none
module run_and_channel_offset_lookup_unit import rcol_pkg::*; #(
  parameter int unsigned MAX_RUNS     = 1024,
  parameter int unsigned ROWS         = 48,
  parameter int unsigned COLUMNS      = 96,
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [23:0]        run_number_i,
  input  wire logic               arm_index_i,
  input  wire logic [1:0]         sector_index_i,
  input  wire logic [5:0]         row_index_i,
  input  wire logic [6:0]         column_index_i,
  input  wire logic signed [15:0] offset_value_i,
  input  wire logic [15:0]        entry_count_i,
  input  wire logic               fit_in_range_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [16:0]      total_offset_o,
  output logic [2:0]              status_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned AW          = $clog2(MAX_RUNS);
  localparam int unsigned CW          = $clog2(MAX_RUNS + 1);
  localparam int unsigned TOWER_COUNT = 8 * ROWS * COLUMNS;
  localparam int unsigned TAW         = $clog2(TOWER_COUNT);
  localparam int unsigned RB_W        = $clog2(8 * ROWS);
  localparam int unsigned TW_W        = OFFSET_WIDTH + 1;
  localparam int unsigned EXT_W       = (OFFSET_WIDTH > TOTAL_W) ? OFFSET_WIDTH : TOTAL_W;

  function automatic logic [TOTAL_W-1:0] ext_ofs(logic [OFFSET_WIDTH-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'($signed(v));
    return w[TOTAL_W-1:0];
  endfunction

  rcol_state_e state_q, state_d;

  // transaction registers
  rcol_op_e          op_q;
  logic [23:0]       run_q;
  logic              large_q;
  logic              idx_ok_q;
  logic              small_range_q;
  logic [RB_W-1:0]   row_base_q;
  logic [6:0]        col_q;
  logic [15:0]       value_q;
  logic [15:0]       nent_q;
  logic              inr_q;

  // configuration, counts, cache
  logic [CFG_W-1:0]   def_run_q;
  logic [CFG_W-1:0]   def_tower_q;
  logic [CW-1:0]      n_small_q;
  logic [CW-1:0]      n_large_q;
  logic [TAW-1:0]     clr_q;
  logic               cache_valid_q;
  logic [23:0]        cached_run_q;
  logic [TOTAL_W-1:0] cached_small_q;
  logic [TOTAL_W-1:0] cached_large_q;
  rcol_status_e       res_status_q;

  // output register
  logic               out_valid_q;
  logic [TOTAL_W-1:0] total_q;
  rcol_status_e       status_q;

  // control
  logic               in_acc;
  logic               cfg_wr;
  logic               out_free;
  logic               run_we;
  logic               run_lane;
  logic               tower_we;
  logic               tower_re;
  logic [TW_W-1:0]    tower_wdata;
  logic [TAW-1:0]     tower_addr;
  logic [TAW-1:0]     tidx;
  logic               search_start;
  logic               invalidate;
  logic               status_load;
  rcol_status_e       status_d;
  logic               cache_fill;
  logic               out_load;
  logic               clr_step;
  logic               cache_hit;
  logic [CW-1:0]      sel_cnt;
  logic               table_full;
  logic               rec_reject;
  logic [TW_W-1:0]    tower_rdata;
  logic [TOTAL_W-1:0] tw_ofs;
  logic [TOTAL_W-1:0] ro_ofs;
  logic [TOTAL_W-1:0] total_d;
  logic               large_d;
  logic               idx_ok_d;
  logic [RB_W-1:0]    row_base_d;

  // run table read side
  logic               run_re;
  logic [AW-1:0]      run_raddr;
  logic [23:0]        small_num;
  logic [OFFSET_WIDTH-1:0] small_ofs;
  logic [23:0]        large_num;
  logic [OFFSET_WIDTH-1:0] large_ofs;
  rcol_search_rsp_t   search_rsp;

  // handshakes
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pready     = 1'b1;

  // register read
  always_comb begin
    if (paddr[2] == REG_DEFAULT_TOWER) begin
      prdata = {16'd0, def_tower_q};
    end else begin
      prdata = {16'd0, def_run_q};
    end
  end

  // tower decode at acceptance
  assign large_d    = arm_index_i && !sector_index_i[1];
  assign idx_ok_d   = (32'(row_index_i) < ROWS) && (32'(column_index_i) < COLUMNS);
  assign row_base_d = RB_W'({arm_index_i, sector_index_i}) * RB_W'(ROWS) + RB_W'(row_index_i);
  assign tidx       = TAW'(row_base_q) * TAW'(COLUMNS) + TAW'(col_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q          <= rcol_op_e'(op_i);
      run_q         <= run_number_i;
      large_q       <= large_d;
      idx_ok_q      <= idx_ok_d;
      small_range_q <= !large_d && ((row_index_i > SMALL_ROW_MAX) ||
                                    (column_index_i > SMALL_COL_MAX));
      row_base_q    <= row_base_d;
      col_q         <= column_index_i;
      value_q       <= offset_value_i;
      nent_q        <= entry_count_i;
      inr_q         <= fit_in_range_i;
    end
  end

  // run record checks
  assign run_lane   = (op_q == OP_LOAD_LARGE);
  assign sel_cnt    = run_lane ? n_large_q : n_small_q;
  assign table_full = (sel_cnt == CW'(MAX_RUNS));
  assign rec_reject = !inr_q || (nent_q < MIN_ENTRIES) || (value_q == '0);
  assign cache_hit  = cache_valid_q && (run_q == cached_run_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == TAW'(TOWER_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((op_q == OP_QUERY) && !cache_hit) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SEARCH: begin
        if (search_rsp.done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    run_we       = 1'b0;
    tower_we     = 1'b0;
    tower_re     = 1'b0;
    tower_wdata  = '0;
    search_start = 1'b0;
    invalidate   = 1'b0;
    status_load  = 1'b0;
    status_d     = ST_OK;
    cache_fill   = 1'b0;
    out_load     = 1'b0;
    clr_step     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        tower_we = 1'b1;
        clr_step = 1'b1;
      end
      S_EXEC: begin
        status_load = 1'b1;
        case (op_q)
          OP_LOAD_SMALL, OP_LOAD_LARGE: begin
            invalidate = 1'b1;
            if (table_full) begin
              status_d = ST_FULL;
            end else if (rec_reject) begin
              status_d = ST_REJECTED;
            end else begin
              run_we = 1'b1;
            end
          end
          OP_LOAD_TOWER: begin
            invalidate = 1'b1;
            if (!idx_ok_q) begin
              status_d = ST_BAD_INDEX;
            end else if (small_range_q) begin
              status_d = ST_SMALL_RANGE;
            end else begin
              tower_we    = 1'b1;
              tower_wdata = {1'b1, OFFSET_WIDTH'(value_q)};
            end
          end
          OP_QUERY: begin
            status_d     = idx_ok_q ? ST_OK : ST_BAD_INDEX;
            tower_re     = idx_ok_q;
            search_start = !cache_hit;
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        cache_fill = search_rsp.done;
      end
      S_FINISH: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign tower_addr = (state_q == S_CLEAR) ? clr_q : tidx;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      def_run_q      <= '0;
      def_tower_q    <= '0;
      n_small_q      <= '0;
      n_large_q      <= '0;
      cache_valid_q  <= 1'b0;
      cached_run_q   <= '0;
      cached_small_q <= '0;
      cached_large_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_step) begin
        clr_q <= clr_q + TAW'(1);
      end
      // configuration writes
      if (cfg_wr) begin
        if (paddr[2] == REG_DEFAULT_TOWER) begin
          def_tower_q <= pwdata[CFG_W-1:0];
        end else begin
          def_run_q <= pwdata[CFG_W-1:0];
        end
      end
      // run table fill counts
      if (run_we) begin
        if (run_lane) begin
          n_large_q <= n_large_q + CW'(1);
        end else begin
          n_small_q <= n_small_q + CW'(1);
        end
      end
      // run offset cache
      if (cfg_wr || invalidate) begin
        cache_valid_q <= 1'b0;
      end else if (cache_fill) begin
        cache_valid_q  <= 1'b1;
        cached_run_q   <= run_q;
        cached_small_q <= search_rsp.small_ofs;
        cached_large_q <= search_rsp.large_ofs;
      end
      // output handshake
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result assembly
  assign tw_ofs  = tower_rdata[OFFSET_WIDTH] ? ext_ofs(tower_rdata[OFFSET_WIDTH-1:0])
                                             : sext_cfg(def_tower_q);
  assign ro_ofs  = large_q ? cached_large_q : cached_small_q;
  assign total_d = ((op_q == OP_QUERY) && idx_ok_q) ? ro_ofs + tw_ofs : '0;

  always_ff @(posedge clk_i) begin
    if (status_load) begin
      res_status_q <= status_d;
    end
    if (out_load) begin
      total_q  <= total_d;
      status_q <= res_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign total_offset_o = $signed(total_q);
  assign status_o       = status_q;

  // run tables
  rcol_run_table #(
    .DEPTH (MAX_RUNS),
    .OFS_W (OFFSET_WIDTH)
  ) u_run_table (
    .clk_i       (clk_i),
    .we_i        (run_we),
    .wlane_i     (run_lane),
    .waddr_i     (AW'(sel_cnt)),
    .wnum_i      (run_q),
    .wofs_i      (OFFSET_WIDTH'(value_q)),
    .re_i        (run_re),
    .raddr_i     (run_raddr),
    .small_num_o (small_num),
    .small_ofs_o (small_ofs),
    .large_num_o (large_num),
    .large_ofs_o (large_ofs)
  );

  // run interval walk
  rcol_search #(
    .MAX_RUNS (MAX_RUNS),
    .OFS_W    (OFFSET_WIDTH)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (search_start),
    .run_i         (run_q),
    .n_small_i     (n_small_q),
    .n_large_i     (n_large_q),
    .default_run_i (def_run_q),
    .small_num_i   (small_num),
    .small_ofs_i   (small_ofs),
    .large_num_i   (large_num),
    .large_ofs_i   (large_ofs),
    .re_o          (run_re),
    .raddr_o       (run_raddr),
    .rsp_o         (search_rsp)
  );

  // tower offsets with written flag
  rcol_tower_table #(
    .DEPTH (TOWER_COUNT),
    .WIDTH (TW_W)
  ) u_tower_table (
    .clk_i   (clk_i),
    .we_i    (tower_we),
    .re_i    (tower_re),
    .addr_i  (tower_addr),
    .wdata_i (tower_wdata),
    .rdata_o (tower_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/rcol_checker.sv =====
`default_nettype none
module rcol_checker import rcol_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_i,
  input wire logic              out_valid_i,
  input wire logic              out_stall_i,
  input wire logic signed [16:0] total_offset_i,
  input wire logic [2:0]        status_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(total_offset_i) && $stable(status_i))
    else $error("stalled result changed");

  // one transaction in flight: stall rises right after acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("second transaction taken while busy");

  // any failing status carries a zero offset
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (total_offset_i == '0))
    else $error("nonzero offset with failing status");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_OK || status_i == ST_REJECTED || status_i == ST_FULL ||
                     status_i == ST_BAD_INDEX || status_i == ST_SMALL_RANGE))
    else $error("undefined status code");

endmodule

bind run_and_channel_offset_lookup_unit rcol_checker u_rcol_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_i     (in_stall_o),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .total_offset_i (total_offset_o),
  .status_i       (status_o)
);
`default_nettype wire
